// ===== hw/rtl/bpa_pkg.sv =====
// Shared types and constants of the bitmap page allocator.
// Request and response payload structs, command and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

   localparam int MAX_PAGES_DEFAULT = 4096;
   localparam int INDEX_LIMIT       = 4096;
   localparam int WORD_BITS         = 64;
   localparam int FRAME_LIMIT_RESET = 4096;

   localparam logic [1:0] CMD_FREE    = 2'd0;
   localparam logic [1:0] CMD_LOCK    = 2'd1;
   localparam logic [1:0] CMD_REQUEST = 2'd2;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_ALREADY   = 2'd1;
   localparam logic [1:0] STATUS_NO_FREE   = 2'd2;
   localparam logic [1:0] STATUS_OUT_RANGE = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [11:0] page_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] result_page;
      logic [12:0] used_pages;
      logic [12:0] free_pages;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bpa_word_store.sv =====
// Usage bitmap storage: one 64-bit word per row, registered read.
// A per-row valid bit makes never-written rows read as all free.
// Uses bpa_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none

module bpa_word_store #(
   parameter int WORDS = bpa_pkg::MAX_PAGES_DEFAULT / bpa_pkg::WORD_BITS,
   parameter int WW    = $clog2(bpa_pkg::MAX_PAGES_DEFAULT / bpa_pkg::WORD_BITS)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [WW-1:0]                  rd_addr,
   output logic      [bpa_pkg::WORD_BITS-1:0]  rd_data,
   input  wire logic                           wr_en,
   input  wire logic [WW-1:0]                  wr_addr,
   input  wire logic [bpa_pkg::WORD_BITS-1:0]  wr_data
);
   import bpa_pkg::*;

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;
   logic [WORDS-1:0]     valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_page_allocator.sv =====
// Top level of the bitmap page frame allocator with next-fit search.
// Instantiates bpa_word_store; uses bpa_pkg for payload types and codes.
//
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   bpa_pkg::req_type (cmd, page_index)
// rsp_      out        rsp_valid/rsp_stall   bpa_pkg::rsp_type (status, page, counts)
// csr_      in         csr_wr_en             csr_wr_data = frame limit
//
// Free and lock step through accept, word read, update and response load.
// An index out of range or an unused command goes from accept straight to response load.
// A request checks one bitmap word per cycle and visits at most WORDS + 1 words
// (the start word twice), so a full miss over 4096 pages reads 65 words.
// Reset clears the row valid bits of the store, so no clearing
// pass is needed. A stalled response holds in its register; the next request may run.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_allocator #(
   parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire bpa_pkg::req_type  req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output bpa_pkg::rsp_type       rsp_payload,
   input  wire logic              csr_wr_en,
   input  wire logic [12:0]       csr_wr_data
);
   import bpa_pkg::*;

   // Only pages below the index limit can ever be addressed, so the map never
   // holds more than that many bits.
   localparam int MAP_BITS = (MAX_PAGES < INDEX_LIMIT) ? MAX_PAGES : INDEX_LIMIT;
   localparam int WORDS    = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WW       = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [12:0] MAP_LIMIT = 13'(MAP_BITS);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_EVAL = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   // Lowest set bit of a word: first the byte, then the bit inside it.
   function automatic logic [5:0] first_set(input logic [WORD_BITS-1:0] v);
      logic [7:0] any_byte;
      logic [2:0] grp;
      logic [2:0] pos;
      logic [7:0] sel;
      any_byte = '0;
      grp      = '0;
      pos      = '0;
      for (int g = 0; g < 8; g++) begin
         any_byte[g] = |v[g*8 +: 8];
      end
      for (int g = 7; g >= 0; g--) begin
         if (any_byte[g]) begin
            grp = 3'(g);
         end
      end
      sel = v[grp*8 +: 8];
      for (int b = 7; b >= 0; b--) begin
         if (sel[b]) begin
            pos = 3'(b);
         end
      end
      return {grp, pos};
   endfunction

   state_type            state_ff, state_in;
   logic [12:0]          frame_limit_ff;
   logic [11:0]          search_start_ff, search_start_in;
   logic [12:0]          used_count_ff, used_count_in;

   logic [1:0]           cmd_ff, cmd_in;
   logic [11:0]          idx_ff, idx_in;
   logic [12:0]          n_ff, n_in;
   logic [WW-1:0]        word_ff, word_in;
   logic [WW-1:0]        start_word_ff, start_word_in;
   logic [5:0]           start_bit_ff, start_bit_in;
   logic [WW-1:0]        last_word_ff, last_word_in;
   logic [6:0]           tail_ff, tail_in;
   logic                 first_ff, first_in;
   logic                 final_ff, final_in;
   logic [1:0]           status_ff, status_in;
   logic [11:0]          page_ff, page_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_payload_ff, rsp_payload_in;

   logic [12:0]          eff_count;
   logic [12:0]          eff_minus_one;
   logic [11:0]          start_page;
   logic [WW-1:0]        next_word;
   logic [WW-1:0]        rd_addr;
   logic [WORD_BITS-1:0] rd_data;
   logic                 wr_en;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] range_mask;
   logic [WORD_BITS-1:0] start_low;
   logic [WORD_BITS-1:0] phase_mask;
   logic [WORD_BITS-1:0] candidates;
   logic [5:0]           hit_bit;
   logic [WORD_BITS-1:0] idx_bit;
   logic                 accept;

   bpa_word_store #(
      .WORDS (WORDS),
      .WW    (WW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // The configured count is capped to the pages the map can hold.
   assign eff_count     = (frame_limit_ff > MAP_LIMIT) ? MAP_LIMIT : frame_limit_ff;
   assign eff_minus_one = eff_count - 13'd1;
   assign start_page    = ({1'b0, search_start_ff} >= eff_count) ? '0 : search_start_ff;

   // The scan wraps after the word that holds the last page in range.
   assign next_word = (word_ff == last_word_ff) ? '0 : word_ff + 1'b1;
   // While scanning, the next word is fetched so that one word is checked per cycle.
   assign rd_addr   = (state_ff == ST_EVAL) ? next_word : word_ff;

   assign range_mask = ((word_ff == last_word_ff) && (tail_ff != 7'd64))
                     ? ((64'd1 << tail_ff[5:0]) - 64'd1) : '1;
   assign start_low  = (64'd1 << start_bit_ff) - 64'd1;
   // The start word is seen twice: first from the start bit up, and at the
   // end of the loop only the bits below the start bit.
   assign phase_mask = first_ff ? ~start_low : (final_ff ? start_low : '1);
   assign candidates = ~rd_data & range_mask & phase_mask;
   assign hit_bit    = first_set(candidates);
   assign idx_bit    = 64'd1 << idx_ff[5:0];

   always_comb begin
      state_in        = state_ff;
      search_start_in = search_start_ff;
      used_count_in   = used_count_ff;
      cmd_in          = cmd_ff;
      idx_in          = idx_ff;
      n_in            = n_ff;
      word_in         = word_ff;
      start_word_in   = start_word_ff;
      start_bit_in    = start_bit_ff;
      last_word_in    = last_word_ff;
      tail_in         = tail_ff;
      first_in        = first_ff;
      final_in        = final_ff;
      status_in       = status_ff;
      page_in         = page_ff;
      wr_en           = 1'b0;
      wr_data         = rd_data;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_payload_in  = rsp_payload_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in        = req_payload.cmd;
               idx_in        = req_payload.page_index;
               page_in       = req_payload.page_index;
               n_in          = eff_count;
               last_word_in  = WW'(eff_minus_one >> 6);
               tail_in       = (eff_count[5:0] == 6'd0) ? 7'd64 : {1'b0, eff_count[5:0]};
               start_word_in = WW'(start_page >> 6);
               start_bit_in  = start_page[5:0];
               first_in      = 1'b1;
               final_in      = 1'b0;
               unique case (req_payload.cmd) inside
                  CMD_FREE, CMD_LOCK: begin
                     if ({1'b0, req_payload.page_index} >= eff_count) begin
                        status_in = STATUS_OUT_RANGE;
                        state_in  = ST_RESP;
                     end else begin
                        word_in  = WW'(req_payload.page_index >> 6);
                        state_in = ST_READ;
                     end
                  end
                  CMD_REQUEST: begin
                     if (eff_count == 13'd0) begin
                        status_in = STATUS_NO_FREE;
                        state_in  = ST_RESP;
                     end else begin
                        word_in  = WW'(start_page >> 6);
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     status_in = STATUS_OUT_RANGE;
                     state_in  = ST_RESP;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            unique case (cmd_ff)
               CMD_FREE: begin
                  state_in = ST_RESP;
                  if ((rd_data & idx_bit) == '0) begin
                     status_in = STATUS_ALREADY;
                  end else begin
                     wr_en     = 1'b1;
                     wr_data   = rd_data & ~idx_bit;
                     status_in = STATUS_DONE;
                     if (used_count_ff != 13'd0) begin
                        used_count_in = used_count_ff - 13'd1;
                     end
                  end
               end
               CMD_LOCK: begin
                  state_in = ST_RESP;
                  if ((rd_data & idx_bit) != '0) begin
                     status_in = STATUS_ALREADY;
                  end else begin
                     wr_en         = 1'b1;
                     wr_data       = rd_data | idx_bit;
                     status_in     = STATUS_DONE;
                     used_count_in = used_count_ff + 13'd1;
                  end
               end
               default: begin
                  if (candidates != '0) begin
                     wr_en           = 1'b1;
                     wr_data         = rd_data | (64'd1 << hit_bit);
                     used_count_in   = used_count_ff + 13'd1;
                     page_in         = 12'({word_ff, hit_bit});
                     search_start_in = 12'({word_ff, hit_bit});
                     status_in       = STATUS_DONE;
                     state_in        = ST_RESP;
                  end else if (final_ff) begin
                     status_in = STATUS_NO_FREE;
                     state_in  = ST_RESP;
                  end else begin
                     word_in  = next_word;
                     first_in = 1'b0;
                     final_in = (next_word == start_word_ff);
                  end
               end
            endcase
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_payload_in.status      = status_ff;
               rsp_payload_in.result_page = page_ff;
               rsp_payload_in.used_pages  = used_count_ff;
               rsp_payload_in.free_pages  = (n_ff > used_count_ff)
                                          ? n_ff - used_count_ff : 13'd0;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_limit_ff  <= 13'(FRAME_LIMIT_RESET);
         search_start_ff <= '0;
         used_count_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         search_start_ff <= search_start_in;
         used_count_ff   <= used_count_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_wr_en) begin
            frame_limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      idx_ff         <= idx_in;
      n_ff           <= n_in;
      word_ff        <= word_in;
      start_word_ff  <= start_word_in;
      start_bit_ff   <= start_bit_in;
      last_word_ff   <= last_word_in;
      tail_ff        <= tail_in;
      first_ff       <= first_in;
      final_ff       <= final_in;
      status_ff      <= status_in;
      page_ff        <= page_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // Once a request is taken, no other may enter until its response is loaded.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request accepted while the previous one is in flight");

   // Every set bit is counted once, so the count never passes the map size.
   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_count_ff <= MAP_LIMIT)
      else $error("used page count exceeds the map size");

   // The word under check never lies past the last word in range.
   a_word_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> (word_ff <= last_word_ff))
      else $error("bitmap word index past the last word in range");

   // A response appears only from the response-load step.
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("response raised outside the response-load step");

endmodule

`default_nettype wire
